// ----- hdl/mht_pkg.sv -----
// shared types, constants and codes for the mru history table
`timescale 1ns / 1ps

package mht_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

  localparam logic [2:0] KIND_SAVE   = 3'd0;
  localparam logic [2:0] KIND_LOOKUP = 3'd1;
  localparam logic [2:0] KIND_DELETE = 3'd2;
  localparam logic [2:0] KIND_RANK   = 3'd3;
  localparam logic [2:0] KIND_UPDATE = 3'd4;
  localparam logic [2:0] KIND_ADD    = 3'd5;
  localparam logic [2:0] KIND_CLEAR  = 3'd6;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_MISSING  = 2'd1;
  localparam logic [1:0] STAT_REJECTED = 2'd2;

  typedef struct packed {
    logic [31:0] key;
    logic [15:0] chapter;
    logic [23:0] page;
    logic [1:0]  book_type;
    logic [31:0] total_time;
    logic [31:0] last_time;
  } rec_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] key;
    logic [15:0] chapter;
    logic [23:0] page;
    logic [1:0]  book_type;
    logic [31:0] total_time;
    logic [31:0] spent_time;
    logic [31:0] now_time;
    logic [3:0]  rank;
    logic        entry_valid;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] out_key;
    logic [15:0] out_chapter;
    logic [23:0] out_page;
    logic [1:0]  out_book_type;
    logic [31:0] out_total_time;
    logic [31:0] out_last_time;
    logic [4:0]  entry_count;
  } out_word_t;

  // search setup for one cell
  typedef struct packed {
    logic load;
    logic by_rank;
    logic rank_hit;
    logic live;
  } cell_cmp_t;

  // shift control for one cell
  typedef struct packed {
    logic take_prev;
    logic take_next;
  } cell_ctl_t;

endpackage

// ----- hdl/mht_cell.sv -----
// one slot of the table: record register, key compare and neighbour shift
`timescale 1ns / 1ps

module mht_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  mht_pkg::cell_cmp_t cmp,
  input  logic [31:0]       search_key,
  input  mht_pkg::cell_ctl_t ctl,
  input  mht_pkg::rec_t     prev_rec,
  input  mht_pkg::rec_t     next_rec,
  output mht_pkg::rec_t     rec,
  output logic              sel
);
  import mht_pkg::*;

  rec_t rec_r;
  rec_t rec_nxt;
  logic sel_r;
  logic sel_nxt;

  always_comb begin
    rec_nxt = rec_r;
    if (ctl.take_prev) begin
      rec_nxt = prev_rec;
    end else if (ctl.take_next) begin
      rec_nxt = next_rec;
    end
  end

  always_comb begin
    sel_nxt = sel_r;
    if (cmp.load) begin
      sel_nxt = cmp.live & (cmp.by_rank ? cmp.rank_hit : (rec_r.key == search_key));
    end
  end

  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r <= 1'b0;
    end else begin
      sel_r <= sel_nxt;
    end
  end

  assign rec = rec_r;
  assign sel = sel_r;

endmodule

// ----- hdl/mru_history_table_top.sv -----
// mru history table: row of record cells with search, move-to-front and delete control
`timescale 1ns / 1ps
//
// Input channel in_valid / in_stall / in_word carries one operation word:
// save, lookup, delete, read by rank, update position, add time or clear.
// Result channel out_valid / out_stall / out_word returns one word for each
// operation with status, the returned record and the entry count.
// Slot 0 of the cell row holds the most recent record, the oldest sits at
// the end. In the accept cycle every cell compares its key (or its rank)
// in parallel and registers the match; once the output register is free,
// the first match is picked, the row shifts by one place towards the back
// (move to front) or the front (delete) and the result word is written to
// the output register. out_valid is set by the same edge that writes the
// result word; a new operation is not accepted while the previous one is
// still executing.
// When the receiver stalls, the result waits in the output register; the
// next word can still be accepted but its execution holds until the output
// register is free, and in_stall stays high meanwhile.
// Reset empties the table (entry count zero) and drops any pending result;
// record contents need no clearing since only live slots are ever read.
//
module mru_history_table_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  mht_pkg::in_word_t   in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output mht_pkg::out_word_t  out_word
);
  import mht_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t     state_r, state_nxt;
  in_word_t   req_r, req_nxt;
  logic [CNT_W-1:0] held_r, held_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_word_t  out_word_r, out_word_nxt;

  rec_t       cell_rec [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] sel;
  cell_cmp_t  cmp [MAX_ENTRIES];
  cell_ctl_t  ctl [MAX_ENTRIES];
  rec_t       front_rec;

  logic       accept;
  logic       out_free;
  logic       fire;
  logic [MAX_ENTRIES-1:0] first_oh;
  logic       hit;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] top;
  rec_t       hit_rec;
  logic       do_front;
  logic       do_delete;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign fire     = (state_r == ST_EXEC) && out_free;

  // cell row
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    assign cmp[i].load     = accept;
    assign cmp[i].by_rank  = (in_word.kind == KIND_RANK);
    assign cmp[i].rank_hit = (32'(in_word.rank) == i);
    assign cmp[i].live     = (held_r > CNT_W'(i));

    assign ctl[i].take_prev = fire && do_front && (IDX_W'(i) <= top);
    assign ctl[i].take_next = fire && do_delete && (IDX_W'(i) >= idx) &&
                              (CNT_W'(i + 1) < held_r);

    mht_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmp        (cmp[i]),
      .search_key (in_word.key),
      .ctl        (ctl[i]),
      .prev_rec   ((i == 0) ? front_rec : cell_rec[(i == 0) ? 0 : i - 1]),
      .next_rec   ((i == MAX_ENTRIES - 1) ? cell_rec[i] :
                   cell_rec[(i == MAX_ENTRIES - 1) ? i : i + 1]),
      .rec        (cell_rec[i]),
      .sel        (sel[i])
    );
  end

  // first match and its record
  assign first_oh = sel & ~(sel - MAX_ENTRIES'(1));
  assign hit      = |sel;

  always_comb begin
    idx     = '0;
    hit_rec = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (first_oh[i]) begin
        idx     = idx | IDX_W'(i);
        hit_rec = hit_rec | cell_rec[i];
      end
    end
  end

  always_comb begin
    front_rec            = '0;
    front_rec.key        = req_r.key;
    front_rec.last_time  = req_r.now_time;
    front_rec.chapter    = req_r.chapter;
    front_rec.page       = req_r.page;
    front_rec.book_type  = req_r.book_type;
    front_rec.total_time = req_r.total_time;
    case (req_r.kind)
      KIND_UPDATE: begin
        front_rec.book_type  = hit_rec.book_type;
        front_rec.total_time = hit_rec.total_time;
      end
      KIND_ADD: begin
        front_rec.chapter    = hit_rec.chapter;
        front_rec.page       = hit_rec.page;
        front_rec.book_type  = hit_rec.book_type;
        front_rec.total_time = hit_rec.total_time + req_r.spent_time;
      end
      default: begin
      end
    endcase
  end

  // operation decode
  always_comb begin
    do_front     = 1'b0;
    do_delete    = 1'b0;
    held_nxt     = held_r;
    top          = idx;
    out_word_nxt = '0;
    out_word_nxt.status = STAT_MISSING;

    case (req_r.kind)
      KIND_SAVE: begin
        if (!req_r.entry_valid) begin
          out_word_nxt.status = STAT_REJECTED;
        end else begin
          do_front = 1'b1;
          out_word_nxt.status = STAT_OK;
          if (!hit) begin
            if (held_r >= CNT_W'(MAX_ENTRIES)) begin
              top = IDX_W'(MAX_ENTRIES - 1);
            end else begin
              top = held_r[IDX_W-1:0];
            end
            held_nxt = CNT_W'(top) + CNT_W'(1);
          end
        end
      end
      KIND_LOOKUP, KIND_RANK: begin
        if (hit) begin
          out_word_nxt.status = STAT_OK;
        end
      end
      KIND_DELETE: begin
        if (hit) begin
          do_delete = 1'b1;
          out_word_nxt.status = STAT_OK;
          held_nxt = held_r - CNT_W'(1);
        end
      end
      KIND_UPDATE, KIND_ADD: begin
        if (hit) begin
          do_front = 1'b1;
          out_word_nxt.status = STAT_OK;
        end
      end
      KIND_CLEAR: begin
        out_word_nxt.status = STAT_OK;
        held_nxt = '0;
      end
      default: begin
      end
    endcase

    if (do_front) begin
      out_word_nxt.out_key        = front_rec.key;
      out_word_nxt.out_chapter    = front_rec.chapter;
      out_word_nxt.out_page       = front_rec.page;
      out_word_nxt.out_book_type  = front_rec.book_type;
      out_word_nxt.out_total_time = front_rec.total_time;
      out_word_nxt.out_last_time  = front_rec.last_time;
    end else if (hit && (req_r.kind == KIND_LOOKUP || req_r.kind == KIND_RANK ||
                         req_r.kind == KIND_DELETE)) begin
      out_word_nxt.out_key        = hit_rec.key;
      out_word_nxt.out_chapter    = hit_rec.chapter;
      out_word_nxt.out_page       = hit_rec.page;
      out_word_nxt.out_book_type  = hit_rec.book_type;
      out_word_nxt.out_total_time = hit_rec.total_time;
      out_word_nxt.out_last_time  = hit_rec.last_time;
    end
    out_word_nxt.entry_count = 5'(held_nxt);
  end

  // sequencing
  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          req_nxt   = in_word;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (fire) begin
        held_r <= held_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt;
    if (fire) begin
      out_word_r <= out_word_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  property p_held_bound;
    @(posedge clk) disable iff (!rst_n) held_r <= CNT_W'(MAX_ENTRIES);
  endproperty
  a_held_bound: assert property (p_held_bound)
    else $error("entry count beyond capacity");

  property p_accept_exec;
    @(posedge clk) disable iff (!rst_n) accept |=> (state_r == ST_EXEC);
  endproperty
  a_accept_exec: assert property (p_accept_exec)
    else $error("accepted word not executed next");

  property p_result_source;
    @(posedge clk) disable iff (!rst_n)
      $rose(out_valid_r) |-> $past(state_r == ST_EXEC);
  endproperty
  a_result_source: assert property (p_result_source)
    else $error("result without execution");

  property p_clear_empties;
    @(posedge clk) disable iff (!rst_n)
      (fire && req_r.kind == KIND_CLEAR) |=> (held_r == '0);
  endproperty
  a_clear_empties: assert property (p_clear_empties)
    else $error("clear left entries");

  property p_single_shift;
    @(posedge clk) disable iff (!rst_n) !(do_front && do_delete);
  endproperty
  a_single_shift: assert property (p_single_shift)
    else $error("row shifted both ways");

endmodule
